>>> rtl/core/lru_pkg.sv
// lru_pkg: shared widths, codes and cell control types for the LRU stack.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

  localparam int TAG_W          = 32;
  localparam int OCC_W          = 8;
  localparam int FRAMES_W       = 8;
  localparam int MAX_FRAMES_DEF = 128;

  // access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // configuration port
  localparam int                  CFG_AW    = 3;
  localparam int                  CFG_DW    = 32;
  localparam logic [CFG_AW-3:0]   REG_FRAMES_IN_USE = 1'b0;  // word index
  localparam logic [FRAMES_W-1:0] FRAMES_RESET      = 8'd128;

  // broadcast to every cell for the word being accepted
  typedef struct packed {
    logic             go;      // word accepted this cycle
    logic             rd;      // lookup enabled
    logic             hit;     // some cell matched
    logic             evict;   // stack full, drop entry 0
    logic             insert;  // append without eviction
    logic [TAG_W-1:0] tag;
  } lru_op_t;

  // per-cell position relative to the fill level
  typedef struct packed {
    logic valid;  // below fill level
    logic last;   // most recent entry
    logic next;   // first free slot
  } lru_pos_t;

endpackage

`default_nettype wire

>>> rtl/core/lru_if.sv
// lru_in_if / lru_out_if: valid-ready channels for access and result words.
// Depends on lru_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lru_in_if;
  import lru_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [TAG_W-1:0] page_tag;

  modport source (output valid, func, page_tag, input ready);
  modport sink   (input valid, func, page_tag, output ready);
endinterface

interface lru_out_if;
  import lru_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic             inserted;
  logic             evicted;
  logic [TAG_W-1:0] evicted_tag;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, hit, inserted, evicted, evicted_tag, occupancy,
                  input ready);
  modport sink   (input valid, hit, inserted, evicted, evicted_tag, occupancy,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/lru_cfg.sv
// lru_cfg: APB-style register file holding frames_in_use.
// Depends on lru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lru_cfg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [lru_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire  [lru_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lru_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output logic [lru_pkg::FRAMES_W-1:0] frames_in_use
);
  import lru_pkg::*;

  logic [FRAMES_W-1:0] frames_r, frames_nxt;
  logic                sel_frames;

  // low two address bits are byte lanes
  assign sel_frames = (cfg_paddr[CFG_AW-1:2] == REG_FRAMES_IN_USE);

  always_comb begin
    frames_nxt = frames_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_frames) begin
      frames_nxt = cfg_pwdata[FRAMES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RESET;
    end else begin
      frames_r <= frames_nxt;
    end
  end

  assign cfg_pready    = 1'b1;
  assign cfg_prdata    = sel_frames ? CFG_DW'(frames_r) : '0;
  assign frames_in_use = frames_r;

endmodule

`default_nettype wire

>>> rtl/core/lru_cell.sv
// lru_cell: one stack slot; compares its tag and shifts toward the LRU end.
// Depends on lru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lru_cell (
  input  wire                       clk,
  input  wire  lru_pkg::lru_op_t    op,
  input  wire  lru_pkg::lru_pos_t   pos,
  input  wire  [lru_pkg::TAG_W-1:0] nbr_tag,   // slot above (more recent)
  input  wire                       seen_in,   // match somewhere below
  output logic                      seen_out,
  output logic                      match,
  output logic [lru_pkg::TAG_W-1:0] tag
);
  import lru_pkg::*;

  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic             seen;
  logic             take_nbr;
  logic             take_tag;

  assign match    = op.rd && pos.valid && (tag_r == op.tag);
  assign seen     = seen_in || match;
  assign seen_out = seen;

  // slots from the hit (or from 0 on evict) up to just below the top close up
  assign take_nbr = ((op.hit && seen) || op.evict) && pos.valid && !pos.last;
  assign take_tag = (pos.last && (op.hit || op.evict)) || (pos.next && op.insert);

  always_comb begin
    tag_nxt = tag_r;
    if (op.go) begin
      if (take_tag) begin
        tag_nxt = op.tag;
      end else if (take_nbr) begin
        tag_nxt = nbr_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign tag = tag_r;

endmodule

`default_nettype wire

>>> rtl/core/lru_page_replacement.sv
// lru_page_replacement: LRU page stack built as a chain of compare cells.
// Depends on lru_pkg, lru_if, lru_cfg, lru_cell.
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+-----------------------------------------
//  in_chan  | in  | valid/ready    | func, page_tag
//  out_chan | out | valid/ready    | hit, inserted, evicted, evicted_tag,
//           |     |                | occupancy
//  cfg_*    | in  | APB write/read | frames_in_use at byte address 0
//
// One word per cycle: the whole stack updates at the accept edge, and the
// result is captured in the output register at that same edge and offered
// from the next cycle on. The critical path is the tag compare plus the
// ripple of the first-match flag up the cell chain.
// A new word is taken while the result register is empty or being drained.
// Reset clears the fill count and result valid; slot tags are never read
// above the fill level so they are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  lru_in_if.sink                     in_chan,
  lru_out_if.source                  out_chan,
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire  [lru_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire  [lru_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [lru_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import lru_pkg::*;

  localparam int CW = $clog2(MAX_FRAMES + 1);     // fill count width
  localparam int WW = (CW > FRAMES_W) ? CW : FRAMES_W;  // limit compare width

  logic [FRAMES_W-1:0]   frames_in_use;
  logic [CW-1:0]         count_r, count_nxt;
  logic [WW-1:0]         lim;
  logic                  full;
  logic                  accept;
  lru_op_t               op;
  lru_pos_t              pos   [MAX_FRAMES];
  logic [TAG_W-1:0]      slot  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES:0]   seen;

  logic             out_valid_r, out_valid_nxt;
  logic             hit_r, inserted_r, evicted_r;
  logic [TAG_W-1:0] evtag_r;
  logic [OCC_W-1:0] occ_r;

  // ---------------- configuration ----------------
  lru_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .frames_in_use (frames_in_use)
  );

  // effective frame limit: zero acts as one, clamp to the cell count
  always_comb begin
    lim = (frames_in_use == '0) ? WW'(1) : WW'(frames_in_use);
    if (lim > WW'(MAX_FRAMES)) begin
      lim = WW'(MAX_FRAMES);
    end
  end

  assign full = (WW'(count_r) >= lim);

  // ---------------- handshake ----------------
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // ---------------- broadcast ----------------
  // hit is the OR of all cell matches; a miss or a write appends
  always_comb begin
    op.go     = accept;
    op.rd     = (in_chan.func == FUNC_READ);
    op.tag    = in_chan.page_tag;
    op.hit    = |match;
    op.evict  = !op.hit && full;
    op.insert = !op.hit && !full;
  end

  // ---------------- cell chain ----------------
  // slot 0 is least recent; the first-match flag ripples upward
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [TAG_W-1:0] nbr;

    assign pos[i].valid = (CW'(i) < count_r);
    assign pos[i].last  = (count_r != '0) && (CW'(i) == count_r - CW'(1));
    assign pos[i].next  = (CW'(i) == count_r);

    if (i == MAX_FRAMES - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = slot[i+1];
    end

    lru_cell u_cell (
      .clk      (clk),
      .op       (op),
      .pos      (pos[i]),
      .nbr_tag  (nbr),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .match    (match[i]),
      .tag      (slot[i])
    );
  end

  // ---------------- fill count ----------------
  always_comb begin
    count_nxt = count_r;
    if (accept && op.insert) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r      <= op.hit;
      inserted_r <= !op.hit;
      evicted_r  <= op.evict;
      evtag_r    <= op.evict ? slot[0] : '0;
      // occupancy saturates at the field maximum
      occ_r      <= (count_nxt > CW'(255)) ? OCC_W'(255) : OCC_W'(count_nxt);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = hit_r;
  assign out_chan.inserted    = inserted_r;
  assign out_chan.evicted     = evicted_r;
  assign out_chan.evicted_tag = evtag_r;
  assign out_chan.occupancy   = occ_r;

endmodule

`default_nettype wire
